FILE: rtl/clock_time_font_formatter_assert.svh
// ----------------------------------------------------------------------------
// Clock time font formatter assertion macros
// Shared property shapes for the checker; clk and rst_n come from the user.
// ----------------------------------------------------------------------------
`ifndef CLOCK_TIME_FONT_FORMATTER_ASSERT_SVH
`define CLOCK_TIME_FONT_FORMATTER_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define CTFF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctff assertion failed");

// Check the consequent in the cycle after the antecedent.
`define CTFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctff assertion failed");

`endif

FILE: rtl/ctff_pkg.sv
// ----------------------------------------------------------------------------
// Clock time font formatter package
// Glyph codes, font ROM, packing shifts and shared types.
// ----------------------------------------------------------------------------
package ctff_pkg;

  typedef logic [3:0] glyph_t;
  typedef logic [2:0] row_t;
  typedef logic [2:0] pix_t;

  localparam glyph_t GLYPH_ONE   = 4'd1;
  localparam glyph_t GLYPH_TWO   = 4'd2;
  localparam glyph_t GLYPH_FOUR  = 4'd4;
  localparam glyph_t GLYPH_EIGHT = 4'd8;
  localparam glyph_t GLYPH_COLON = 4'd10;
  localparam glyph_t GLYPH_A     = 4'd11;
  localparam glyph_t GLYPH_P     = 4'd12;
  localparam glyph_t GLYPH_BLANK = 4'd13;

  localparam logic [16:0] DAY_SECONDS  = 17'd86400;
  localparam logic [16:0] NOON_SECONDS = 17'd43200;

  // Reciprocals for divide by 15 (seconds/4 -> minutes, minutes/4 -> hours)
  localparam logic [15:0] RECIP_MIN  = 16'd34953;  // ceil(2^19 / 15)
  localparam int          SHIFT_MIN  = 19;
  localparam logic [9:0]  RECIP_HOUR = 10'd547;    // ceil(2^13 / 15)
  localparam int          SHIFT_HOUR = 13;

  localparam row_t LAST_ROW = 3'd4;

  // Glyph slots, right to left
  localparam int POS_SEC_ONES  = 0;
  localparam int POS_SEC_TENS  = 1;
  localparam int POS_COLON_LO  = 2;
  localparam int POS_MIN_ONES  = 3;
  localparam int POS_MIN_TENS  = 4;
  localparam int POS_COLON_HI  = 5;
  localparam int POS_HOUR_ONES = 6;
  localparam int POS_HOUR_TENS = 7;
  localparam int POS_SUFFIX    = 8;
  localparam int NUM_GLYPHS    = 9;

  localparam int GLYPH_SHIFT [NUM_GLYPHS] = '{0, 4, 6, 10, 14, 16, 20, 24, 28};

  typedef struct packed {
    glyph_t [NUM_GLYPHS-1:0] glyph;
    logic                    fmt24;
  } ctff_glyphs_t;

  // All five rows of a glyph, row 0 in the top bits.
  function automatic logic [14:0] glyph_rows(glyph_t g);
    case (g)
      4'd0:        return {3'h7, 3'h5, 3'h5, 3'h5, 3'h7};
      4'd1:        return {3'h6, 3'h2, 3'h2, 3'h2, 3'h7};
      4'd2:        return {3'h7, 3'h1, 3'h7, 3'h4, 3'h7};
      4'd3:        return {3'h7, 3'h1, 3'h7, 3'h1, 3'h7};
      4'd4:        return {3'h5, 3'h5, 3'h7, 3'h1, 3'h1};
      4'd5:        return {3'h7, 3'h4, 3'h7, 3'h1, 3'h7};
      4'd6:        return {3'h7, 3'h4, 3'h7, 3'h5, 3'h7};
      4'd7:        return {3'h7, 3'h1, 3'h1, 3'h1, 3'h1};
      4'd8:        return {3'h7, 3'h5, 3'h7, 3'h5, 3'h7};
      4'd9:        return {3'h7, 3'h5, 3'h7, 3'h1, 3'h7};
      GLYPH_COLON: return {3'h0, 3'h4, 3'h0, 3'h4, 3'h0};
      GLYPH_A:     return {3'h2, 3'h5, 3'h7, 3'h5, 3'h5};
      GLYPH_P:     return {3'h7, 3'h5, 3'h7, 3'h4, 3'h4};
      default:     return 15'd0;
    endcase
  endfunction

  function automatic pix_t glyph_row(glyph_t g, row_t row);
    logic [14:0] r;
    r = glyph_rows(g);
    case (row)
      3'd0:    return r[14:12];
      3'd1:    return r[11:9];
      3'd2:    return r[8:6];
      3'd3:    return r[5:3];
      3'd4:    return r[2:0];
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [31:0] pack_row(ctff_glyphs_t gs, row_t row);
    logic [31:0] bits;
    bits = '0;
    for (int n = 0; n < NUM_GLYPHS; n++) begin
      bits = bits | (32'(glyph_row(gs.glyph[n], row)) << GLYPH_SHIFT[n]);
    end
    return bits;
  endfunction

  function automatic logic [15:0] label_row(logic fmt24, row_t row);
    if (fmt24) begin
      return {1'b0, glyph_row(GLYPH_TWO, row), 1'b0, glyph_row(GLYPH_FOUR, row), 8'd0};
    end
    return {1'b0, glyph_row(GLYPH_ONE, row), 1'b0, glyph_row(GLYPH_TWO, row), 8'd0};
  endfunction

  // Tens and ones glyphs of a value below 60.
  function automatic logic [7:0] split_tens(logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] ones;
    if (v >= 6'd50) begin
      tens = 4'd5; ones = v - 6'd50;
    end else if (v >= 6'd40) begin
      tens = 4'd4; ones = v - 6'd40;
    end else if (v >= 6'd30) begin
      tens = 4'd3; ones = v - 6'd30;
    end else if (v >= 6'd20) begin
      tens = 4'd2; ones = v - 6'd20;
    end else if (v >= 6'd10) begin
      tens = 4'd1; ones = v - 6'd10;
    end else begin
      tens = 4'd0; ones = v;
    end
    return {tens, ones[3:0]};
  endfunction

endpackage

FILE: rtl/clock_time_font_formatter.sv
// ----------------------------------------------------------------------------
// Clock time font formatter
// Converts a seconds-of-day count into five LED-matrix row bitmaps of
// HH:MM:SS plus an A/P suffix in twelve-hour format, with the 12/24 label on every row.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   in_seconds_of_day (17b)
//   out_     out  out_valid / out_ready row index, row bits, label, last row
//   cfg_     in   cfg_valid / cfg_ready cfg_hour_format (1b)
//
// Each request yields five result rows, top row first. The row generator
// emits one row per cycle while out_ready is high and takes the next glyph
// set as its last row goes out. A request passes the four arithmetic stages,
// the row generator load and the output register before its first row shows.
// Reset clears every valid bit and selects the twenty-four-hour format.
// A low out_ready holds the current row and backs up the pipeline stage by
// stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module clock_time_font_formatter import ctff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] in_seconds_of_day,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_row_index,
  output logic [31:0] out_row_bits,
  output logic [15:0] out_format_label_bits,
  output logic        out_last_row,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_hour_format
);

  // Hour format register: 0 twelve-hour with A/P, 1 twenty-four-hour
  logic         hour_format_r;

  // Glyph set handed from the arithmetic pipeline to the row generator
  logic         mid_valid;
  logic         mid_ready;
  ctff_glyphs_t mid_glyphs;

  // Always take configuration writes; they must arrive only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_format_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      hour_format_r <= cfg_hour_format;
    end
  end

  // Split seconds into hour, minute and second glyphs over four stages.
  // The format travels with each request so a row set is self-contained.
  ctff_time_split u_split (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_seconds  (in_seconds_of_day),
    .hour_format (hour_format_r),
    .dn_valid    (mid_valid),
    .dn_ready    (mid_ready),
    .dn_glyphs   (mid_glyphs)
  );

  // Walk the font rows of the held glyph set and register each result.
  ctff_row_gen u_rows (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .up_valid              (mid_valid),
    .up_ready              (mid_ready),
    .up_glyphs             (mid_glyphs),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_row_index         (out_row_index),
    .out_row_bits          (out_row_bits),
    .out_format_label_bits (out_format_label_bits),
    .out_last_row          (out_last_row)
  );

endmodule

FILE: rtl/ctff_time_split.sv
// ----------------------------------------------------------------------------
// Time split pipeline
// Four stages turning seconds of day into the nine glyph codes of one item.
// ----------------------------------------------------------------------------
module ctff_time_split import ctff_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [16:0]  in_seconds,
  input  logic         hour_format,
  output logic         dn_valid,
  input  logic         dn_ready,
  output ctff_glyphs_t dn_glyphs
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic s1_adv, s2_adv, s3_adv, s4_adv;

  logic [16:0] t1_r, t2_r;
  logic        fmt1_r, fmt2_r, fmt3_r;
  logic        err2_r, err3_r;
  logic        pm2_r, pm3_r;
  logic [11:0] m2_r, m3_r;
  logic [11:0] m2_nxt;
  logic [5:0]  h3_r, h3_nxt;
  logic [5:0]  sec3_r, sec3_nxt;
  ctff_glyphs_t glyph4_r, glyph4_nxt;

  logic [30:0] min_prod;
  logic [19:0] hour_prod;
  logic [17:0] m_times60;
  logic [17:0] sec_full;
  logic [11:0] h_times60;
  logic [11:0] min_full;
  logic [5:0]  min4;
  logic [5:0]  hr4;
  logic [7:0]  sec_dig, min_dig, hr_dig;

  assign s4_adv   = !v4_r || dn_ready;
  assign s3_adv   = !v3_r || s4_adv;
  assign s2_adv   = !v2_r || s3_adv;
  assign s1_adv   = !v1_r || s2_adv;
  assign in_ready = s1_adv;
  assign dn_valid = v4_r;
  assign dn_glyphs = glyph4_r;

  // Stage 2: total minutes
  assign min_prod = 31'(t1_r[16:2]) * 31'(RECIP_MIN);
  assign m2_nxt   = min_prod[SHIFT_MIN +: 12];

  // Stage 3: hours and seconds
  assign hour_prod = 20'(m2_r[11:2]) * 20'(RECIP_HOUR);
  assign h3_nxt    = hour_prod[SHIFT_HOUR +: 6];
  assign m_times60 = {m2_r, 6'd0} - {4'd0, m2_r, 2'd0};
  assign sec_full  = {1'b0, t2_r} - m_times60;
  assign sec3_nxt  = sec_full[5:0];

  // Stage 4: minutes, hour format, digit split
  assign h_times60 = {h3_r, 6'd0} - {4'd0, h3_r, 2'd0};
  assign min_full  = m3_r - h_times60;
  assign min4      = min_full[5:0];

  always_comb begin
    hr4 = h3_r;
    if (!fmt3_r) begin
      if (h3_r >= 6'd12) begin
        hr4 = h3_r - 6'd12;
      end
      if (hr4 == 6'd0) begin
        hr4 = 6'd12;
      end
    end
    sec_dig = split_tens(sec3_r);
    min_dig = split_tens(min4);
    hr_dig  = split_tens(hr4);

    glyph4_nxt.fmt24                = fmt3_r;
    glyph4_nxt.glyph[POS_SEC_ONES]  = sec_dig[3:0];
    glyph4_nxt.glyph[POS_SEC_TENS]  = sec_dig[7:4];
    glyph4_nxt.glyph[POS_COLON_LO]  = GLYPH_COLON;
    glyph4_nxt.glyph[POS_MIN_ONES]  = min_dig[3:0];
    glyph4_nxt.glyph[POS_MIN_TENS]  = min_dig[7:4];
    glyph4_nxt.glyph[POS_COLON_HI]  = GLYPH_COLON;
    glyph4_nxt.glyph[POS_HOUR_ONES] = hr_dig[3:0];
    glyph4_nxt.glyph[POS_HOUR_TENS] = hr_dig[7:4];
    if (fmt3_r) begin
      glyph4_nxt.glyph[POS_SUFFIX] = GLYPH_BLANK;
    end else begin
      glyph4_nxt.glyph[POS_SUFFIX] = pm3_r ? GLYPH_P : GLYPH_A;
    end

    // Out-of-day count: show 88:88:88, blank suffix
    if (err3_r) begin
      glyph4_nxt.glyph[POS_SEC_ONES]  = GLYPH_EIGHT;
      glyph4_nxt.glyph[POS_SEC_TENS]  = GLYPH_EIGHT;
      glyph4_nxt.glyph[POS_MIN_ONES]  = GLYPH_EIGHT;
      glyph4_nxt.glyph[POS_MIN_TENS]  = GLYPH_EIGHT;
      glyph4_nxt.glyph[POS_HOUR_ONES] = GLYPH_EIGHT;
      glyph4_nxt.glyph[POS_HOUR_TENS] = GLYPH_EIGHT;
      glyph4_nxt.glyph[POS_SUFFIX]    = GLYPH_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (s1_adv) v1_r <= in_valid;
      if (s2_adv) v2_r <= v1_r;
      if (s3_adv) v3_r <= v2_r;
      if (s4_adv) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      t1_r   <= in_seconds;
      fmt1_r <= hour_format;
    end
    if (s2_adv) begin
      t2_r   <= t1_r;
      m2_r   <= m2_nxt;
      fmt2_r <= fmt1_r;
      err2_r <= (t1_r >= DAY_SECONDS);
      pm2_r  <= (t1_r >= NOON_SECONDS);
    end
    if (s3_adv) begin
      h3_r   <= h3_nxt;
      sec3_r <= sec3_nxt;
      m3_r   <= m2_r;
      fmt3_r <= fmt2_r;
      err3_r <= err2_r;
      pm3_r  <= pm2_r;
    end
    if (s4_adv) begin
      glyph4_r <= glyph4_nxt;
    end
  end

endmodule

FILE: rtl/ctff_row_gen.sv
// ----------------------------------------------------------------------------
// Row generator
// Holds one glyph set and emits its five font rows, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ctff_row_gen import ctff_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  ctff_glyphs_t up_glyphs,
  output logic         out_valid,
  input  logic         out_ready,
  output row_t         out_row_index,
  output logic [31:0]  out_row_bits,
  output logic [15:0]  out_format_label_bits,
  output logic         out_last_row
);

  ctff_glyphs_t glyphs_r;
  logic         busy_r;
  row_t         row_r;
  logic         out_valid_r;
  row_t         out_row_index_r;
  logic [31:0]  out_row_bits_r;
  logic [15:0]  out_label_r;
  logic         out_last_r;
  logic         emit;
  logic         emit_last;

  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign emit_last = emit && (row_r == LAST_ROW);
  assign up_ready  = !busy_r || emit_last;

  assign out_valid             = out_valid_r;
  assign out_row_index         = out_row_index_r;
  assign out_row_bits          = out_row_bits_r;
  assign out_format_label_bits = out_label_r;
  assign out_last_row          = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (up_valid && up_ready) begin
        busy_r <= 1'b1;
        row_r  <= '0;
      end else if (emit_last) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        row_r <= row_r + 3'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      glyphs_r <= up_glyphs;
    end
    if (emit) begin
      out_row_index_r <= row_r;
      out_row_bits_r  <= pack_row(glyphs_r, row_r);
      out_label_r     <= label_row(glyphs_r.fmt24, row_r);
      out_last_r      <= (row_r == LAST_ROW);
    end
  end

endmodule

FILE: rtl/ctff_checker.sv
// ----------------------------------------------------------------------------
// Clock time font formatter checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "clock_time_font_formatter_assert.svh"

module ctff_checker import ctff_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_row_index,
  input logic [31:0] out_row_bits,
  input logic [15:0] out_format_label_bits,
  input logic        out_last_row
);

  logic       out_stall;
  logic       row_more;
  logic [2:0] next_index_r;

  assign out_stall = out_valid && !out_ready;
  assign row_more  = out_valid && out_ready && !out_last_row;

  // Track the index the following row must carry
  always_ff @(posedge clk) begin
    next_index_r <= out_row_index + 3'd1;
  end

  // A stalled row stays valid and keeps its index
  `CTFF_ASSERT_NEXT(a_out_hold_valid, out_stall, out_valid && $stable(out_row_index))

  // A stalled row keeps its payload
  `CTFF_ASSERT_NEXT(a_out_hold_data, out_stall, $stable({out_row_bits, out_format_label_bits}))

  // Last-row flag marks the bottom font row only
  `CTFF_ASSERT_SAME(a_last_flag, out_valid, out_last_row == (out_row_index == LAST_ROW))

  // Rows of one request follow each other without gaps
  `CTFF_ASSERT_NEXT(a_row_advance, row_more, out_valid && out_row_index == next_index_r)

endmodule

bind clock_time_font_formatter ctff_checker u_ctff_checker (.*);

FILE: dv/clock_time_font_formatter_checker.sv
// ----------------------------------------------------------------------------
// Clock time font formatter checker
// Watches the request, result and format-write channels, renders the five
// expected glyph rows of every accepted request and compares each result row
// field by field against the oldest pending one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package ctff_tb_pkg;

  typedef enum logic {
    FMT_12H = 1'b0,
    FMT_24H = 1'b1
  } hour_fmt_e;

endpackage

module clock_time_font_formatter_checker
  import ctff_pkg::*;
  import ctff_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [16:0] in_seconds_of_day,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_row_index,
  input  logic [31:0] out_row_bits,
  input  logic [15:0] out_format_label_bits,
  input  logic        out_last_row,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_hour_format,
  output int          mismatches,
  output int          rows_pending,
  output int          rows_checked
);

  typedef struct packed {
    logic [2:0]  row_index;
    logic [31:0] row_bits;
    logic [15:0] label_bits;
    logic        last_row;
  } clock_row_t;

  localparam int NUM_SLOTS = 9;
  localparam int NUM_ROWS  = 5;
  localparam int SLOT_SHIFT [NUM_SLOTS] = '{0, 4, 6, 10, 14, 16, 20, 24, 28};

  clock_row_t  expected_rows [$];
  hour_fmt_e   hour_fmt;
  logic [14:0] font [0:13];   // row 0 in bits 14:12, row 4 in bits 2:0
  int          mismatch_cnt = 0;
  int          checked_cnt  = 0;

  assign mismatches   = mismatch_cnt;
  assign rows_checked = checked_cnt;

  initial begin
    font[0]           = {3'h7, 3'h5, 3'h5, 3'h5, 3'h7};
    font[1]           = {3'h6, 3'h2, 3'h2, 3'h2, 3'h7};
    font[2]           = {3'h7, 3'h1, 3'h7, 3'h4, 3'h7};
    font[3]           = {3'h7, 3'h1, 3'h7, 3'h1, 3'h7};
    font[4]           = {3'h5, 3'h5, 3'h7, 3'h1, 3'h1};
    font[5]           = {3'h7, 3'h4, 3'h7, 3'h1, 3'h7};
    font[6]           = {3'h7, 3'h4, 3'h7, 3'h5, 3'h7};
    font[7]           = {3'h7, 3'h1, 3'h1, 3'h1, 3'h1};
    font[8]           = {3'h7, 3'h5, 3'h7, 3'h5, 3'h7};
    font[9]           = {3'h7, 3'h5, 3'h7, 3'h1, 3'h7};
    font[GLYPH_COLON] = {3'h0, 3'h4, 3'h0, 3'h4, 3'h0};
    font[GLYPH_A]     = {3'h2, 3'h5, 3'h7, 3'h5, 3'h5};
    font[GLYPH_P]     = {3'h7, 3'h5, 3'h7, 3'h4, 3'h4};
    font[GLYPH_BLANK] = '0;
  end

  function automatic logic [2:0] font_row(glyph_t g, int r);
    return font[g][12 - 3 * r +: 3];
  endfunction

  // Queue the five rows that a request for this count must produce.
  function automatic void render_clock_rows(logic [16:0] secs, hour_fmt_e fmt);
    glyph_t      slot [NUM_SLOTS];
    int          hh;
    int          mm;
    int          ss;
    clock_row_t  row;
    if (secs < DAY_SECONDS) begin
      hh = secs / 3600;
      mm = (secs / 60) % 60;
      ss = secs % 60;
      if (fmt == FMT_12H) begin
        hh = hh % 12;
        if (hh == 0) hh = 12;
        slot[8] = (secs < NOON_SECONDS) ? GLYPH_A : GLYPH_P;
      end else begin
        slot[8] = GLYPH_BLANK;
      end
      slot[0] = glyph_t'(ss % 10);
      slot[1] = glyph_t'(ss / 10);
      slot[2] = GLYPH_COLON;
      slot[3] = glyph_t'(mm % 10);
      slot[4] = glyph_t'(mm / 10);
      slot[5] = GLYPH_COLON;
      slot[6] = glyph_t'(hh % 10);
      slot[7] = glyph_t'(hh / 10);
    end else begin
      for (int n = 0; n < NUM_SLOTS; n++) slot[n] = GLYPH_EIGHT;
      slot[2] = GLYPH_COLON;
      slot[5] = GLYPH_COLON;
      slot[8] = GLYPH_BLANK;
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      row.row_index = 3'(r);
      row.row_bits  = '0;
      for (int n = 0; n < NUM_SLOTS; n++)
        row.row_bits = row.row_bits | (32'(font_row(slot[n], r)) << SLOT_SHIFT[n]);
      if (fmt == FMT_12H)
        row.label_bits = {1'b0, font_row(GLYPH_ONE, r), 1'b0, font_row(GLYPH_TWO, r), 8'h00};
      else
        row.label_bits = {1'b0, font_row(GLYPH_TWO, r), 1'b0, font_row(GLYPH_FOUR, r), 8'h00};
      row.last_row = (r == NUM_ROWS - 1);
      expected_rows.push_back(row);
    end
  endfunction

  always @(posedge clk) begin
    clock_row_t want;
    if (!rst_n) begin
      hour_fmt = FMT_24H;
      expected_rows.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $error("result row %0d arrived with no request pending", out_row_index);
          mismatch_cnt++;
        end else begin
          want = expected_rows.pop_front();
          checked_cnt++;
          if (out_row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, out_row_index);
            mismatch_cnt++;
          end
          if (out_row_bits !== want.row_bits) begin
            $error("row_bits: expected %08h, got %08h", want.row_bits, out_row_bits);
            mismatch_cnt++;
          end
          if (out_format_label_bits !== want.label_bits) begin
            $error("format_label_bits: expected %04h, got %04h",
                   want.label_bits, out_format_label_bits);
            mismatch_cnt++;
          end
          if (out_last_row !== want.last_row) begin
            $error("last_row: expected %0d, got %0d", want.last_row, out_last_row);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) render_clock_rows(in_seconds_of_day, hour_fmt);
      if (cfg_valid && cfg_ready) hour_fmt = hour_fmt_e'(cfg_hour_format);
    end
    rows_pending <= expected_rows.size();
  end

endmodule

FILE: dv/tb_clock_time_font_formatter.sv
// ----------------------------------------------------------------------------
// Clock time font formatter testbench
// Drives seconds-of-day requests and hour-format writes into the formatter,
// with random gaps on both channels and one long result stall, and leaves
// the row-by-row comparison to the checker placed beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_clock_time_font_formatter;
  import ctff_pkg::*;
  import ctff_tb_pkg::*;

  localparam int NUM_PHASES   = 8;
  localparam int HOLD_CYCLES  = 200;   // long result stall, fills the pipeline
  localparam int DRAIN_CYCLES = 16;    // covers a request's path through the block plus a full row burst

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [16:0] in_seconds_of_day = '0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [2:0]  out_row_index;
  logic [31:0] out_row_bits;
  logic [15:0] out_format_label_bits;
  logic        out_last_row;
  logic        cfg_valid         = 1'b0;
  logic        cfg_ready;
  logic        cfg_hour_format   = 1'b0;

  int mismatches;
  int rows_pending;
  int rows_checked;

  // Knobs shared between the request driver and the result sink.
  int in_idle_pct   = 20;
  int out_idle_pct  = 20;
  bit hold_request  = 1'b0;

  // Run statistics for the closing summary.
  int requests_sent = 0;
  int past_day_sent = 0;
  int fmt_writes    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  clock_time_font_formatter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_seconds_of_day     (in_seconds_of_day),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_row_index         (out_row_index),
    .out_row_bits          (out_row_bits),
    .out_format_label_bits (out_format_label_bits),
    .out_last_row          (out_last_row),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_hour_format       (cfg_hour_format)
  );

  clock_time_font_formatter_checker checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_seconds_of_day     (in_seconds_of_day),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_row_index         (out_row_index),
    .out_row_bits          (out_row_bits),
    .out_format_label_bits (out_format_label_bits),
    .out_last_row          (out_last_row),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_hour_format       (cfg_hour_format),
    .mismatches            (mismatches),
    .rows_pending          (rows_pending),
    .rows_checked          (rows_checked)
  );

  // Result sink: drop ready at random, and once on request hold it low for
  // a long stretch so the block backs up and stalls its request channel.
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Offer one request, with random idle cycles ahead of it. Leave valid high
  // on return so a back-to-back request follows without a bubble.
  task automatic send_time(input logic [16:0] secs);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_seconds_of_day <= secs;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (secs >= DAY_SECONDS) past_day_sent++;
  endtask

  // Change the hour format only once every pending row has come out.
  task automatic write_format(input hour_fmt_e fmt);
    in_valid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
    cfg_valid       <= 1'b1;
    cfg_hour_format <= fmt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fmt_writes++;
  endtask

  // Mostly plain times of day, some right around an hour boundary (midnight,
  // noon and the end of day among them), the rest past the end of the day.
  function automatic logic [16:0] pick_seconds();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 10) return 17'($urandom_range(131071, 86400));
    if (pick < 22) begin
      v = 3600 * int'($urandom_range(24)) + int'($urandom_range(2)) - 1;
      if (v < 0) v = 0;
      return 17'(v);
    end
    return 17'($urandom_range(86399));
  endfunction

  initial begin : stimulus
    int phase_items;
    int fmt_pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset format is twenty-four-hour: midnight, mid-day, the noon edge,
    // end of day, the first invalid count and the all-ones count.
    send_time(17'd0);
    send_time(17'd45296);
    send_time(17'd43199);
    send_time(17'd43200);
    send_time(17'd72000);
    send_time(17'd86399);
    send_time(17'd86400);
    send_time(17'd131071);

    // Twelve-hour format: midnight shows as 12 A, noon as 12 P, and the
    // out-of-range display ignores the format.
    write_format(FMT_12H);
    send_time(17'd0);
    send_time(17'd3599);
    send_time(17'd3600);
    send_time(17'd43199);
    send_time(17'd43200);
    send_time(17'd46800);
    send_time(17'd45296);
    send_time(17'd86399);
    send_time(17'd86400);
    send_time(17'd131071);

    write_format(FMT_24H);
    send_time(17'd0);
    send_time(17'd86399);

    // Random phases with alternating format. Phase 2 runs with no idling on
    // either side; phase 5 carries the long result stall.
    fmt_pick = $urandom_range(1);
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_format(hour_fmt_e'(fmt_pick ^ (phase % 2)));
      in_idle_pct   = (phase == 2) ? 0 : 20;
      out_idle_pct <= (phase == 2) ? 0 : 20;
      if (phase == 5) hold_request <= 1'b1;
      phase_items = $urandom_range(66, 46);
      for (int i = 0; i < phase_items; i++) send_time(pick_seconds());
    end

    // Drain: wait for every pending row, then give stray rows time to show.
    in_valid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d past end of day) over %0d hour-format writes,",
             requests_sent, past_day_sent, fmt_writes);
    $display("and compared %0d result rows, one long result stall included.", rows_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: a correct run needs a small fraction of this.
  initial begin : watchdog
    #2000000;
    $display("Timed out waiting on the block");
    $display("Mismatches found");
    $finish;
  end

endmodule
